/* design/totp_hmac_sha1_generator_unit_assert.svh */
// Assertion macros for the TOTP generator.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef TOTP_HMAC_SHA1_GENERATOR_UNIT_ASSERT_SVH
`define TOTP_HMAC_SHA1_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TOTP_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define TOTP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* design/totp_pkg.sv */
// Shared types and constants for the TOTP generator.
// No dependencies.
package totp_pkg;
	localparam int unsigned TIME_W = 63;
	localparam int unsigned NUM_KEY_WORDS = 7;
	localparam int unsigned KEY_BYTES_DEF = 56;
	localparam int unsigned TIME_STEP_DEF = 30;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned DIGIT_COUNT_IDX = 7;
	localparam logic [31:0] IPAD_WORD = 32'h3636_3636;
	localparam logic [31:0] OPAD_WORD = 32'h5c5c_5c5c;
	localparam logic [31:0] PAD_WORD = 32'h8000_0000;
	localparam logic [31:0] INNER_LEN_BITS = 32'd576;
	localparam logic [31:0] OUTER_LEN_BITS = 32'd672;
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

	localparam logic [31:0] IV0 = 32'h6745_2301;
	localparam logic [31:0] IV1 = 32'hEFCD_AB89;
	localparam logic [31:0] IV2 = 32'h98BA_DCFE;
	localparam logic [31:0] IV3 = 32'h1032_5476;
	localparam logic [31:0] IV4 = 32'hC3D2_E1F0;

	localparam logic [31:0] K0 = 32'h5A82_7999;
	localparam logic [31:0] K1 = 32'h6ED9_EBA1;
	localparam logic [31:0] K2 = 32'h8F1B_BCDC;
	localparam logic [31:0] K3 = 32'hCA62_C1D6;

	typedef logic [NUM_KEY_WORDS-1:0][63:0] key_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;
endpackage

/* design/totp_hmac_sha1_generator_unit.sv */
// Top level of the TOTP generator: configuration registers, front, queue, back.
// Depends on totp_pkg, totp_front, totp_fifo, totp_back and the assertion header.
//
// Usage:
//   Load the key with wr_en/wr_index/wr_data (indexes 0..6, key bytes 8n..8n+7,
//   first byte in the top bits) and the digit count at index 7 (low four bits).
//   Write only while no request is in flight.
//   A request is a transfer on start while busy is low; unix_time is sampled then.
//   The front divides by the time step with a reciprocal multiply and queues the
//   counter (two entries); busy stays high until the counter is pushed, which
//   waits while the queue is full.
//   The back runs four SHA-1 compressions at one round a cycle, each between a load
//   and a finish step, then truncates and converts the digits one by one.
//   Digits follow on consecutive cycles with digit_valid high, most significant
//   first, last_digit marking the final one; the receiver cannot stall them.
//   The front can accept a new request while the back still hashes an earlier
//   one; sustained throughput is set by the hash in the back.
//   Reset clears the key to zero, the digit count to six and drops all work.
`include "totp_hmac_sha1_generator_unit_assert.svh"

module totp_hmac_sha1_generator_unit #(
	parameter int unsigned KEY_BYTES = totp_pkg::KEY_BYTES_DEF,
	parameter int unsigned TIME_STEP_SECONDS = totp_pkg::TIME_STEP_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [totp_pkg::TIME_W-1:0]    unix_time,
	output logic                           digit_valid,
	output logic [3:0]                     digit,
	output logic                           last_digit,
	input  logic                           wr_en,
	input  logic [totp_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [63:0]                    wr_data
);
	import totp_pkg::*;

	key_t              key_q;
	logic [3:0]        otp_len_q;
	q_stat_t           q_stat;
	logic              push;
	logic [TIME_W-1:0] push_data;
	logic              pop;
	logic [TIME_W-1:0] pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			otp_len_q <= 4'd6;
		end else if (wr_en) begin
			if (wr_index == CFG_IDX_W'(DIGIT_COUNT_IDX)) begin
				otp_len_q <= wr_data[3:0];
			end else begin
				key_q[wr_index] <= wr_data;
			end
		end
	end

	totp_front #(
		.TIME_STEP_SECONDS(TIME_STEP_SECONDS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.unix_time(unix_time),
		.busy(busy),
		.q_stat(q_stat),
		.push(push),
		.push_data(push_data)
	);

	totp_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.pop_data(pop_data),
		.q_stat(q_stat)
	);

	totp_back #(
		.KEY_BYTES(KEY_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.pop(pop),
		.pop_data(pop_data),
		.key(key_q),
		.otp_len(otp_len_q),
		.digit_valid(digit_valid),
		.digit(digit),
		.last_digit(last_digit)
	);

	`TOTP_ASSERT_NOW(a_digit_decimal, digit_valid, digit <= 4'd9, "digit out of decimal range")
	`TOTP_ASSERT_NEXT(a_start_taken, start && !busy, busy, "accepted request not held")
	`TOTP_ASSERT_NEXT(a_run_contiguous, digit_valid && !last_digit, digit_valid, "gap in digit run")
	`TOTP_ASSERT_NEXT(a_run_ends, digit_valid && last_digit, !digit_valid, "digit after last")
endmodule

/* design/totp_front.sv */
// Front end: takes a time stamp and divides it by the time step with a reciprocal
// multiply, one 32x32 partial product a cycle. Depends on totp_pkg.
module totp_front #(
	parameter int unsigned TIME_STEP_SECONDS = totp_pkg::TIME_STEP_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [totp_pkg::TIME_W-1:0]   unix_time,
	output logic                          busy,
	input  totp_pkg::q_stat_t             q_stat,
	output logic                          push,
	output logic [totp_pkg::TIME_W-1:0]   push_data
);
	import totp_pkg::*;

	localparam int unsigned STEP_LOG2 = $clog2(TIME_STEP_SECONDS);
	localparam int unsigned SH = TIME_W + STEP_LOG2;

	// ceil(2^SH / step) fits 64 bits and is exact for every 63-bit dividend
	function automatic logic [63:0] recip_const();
		logic [127:0] num;
		num = 128'd1 << SH;
		return 64'((num + 128'(TIME_STEP_SECONDS - 1)) / 128'(TIME_STEP_SECONDS));
	endfunction

	localparam logic [63:0] RECIP = recip_const();

	logic              run_q;
	logic              done_q;
	logic [1:0]        cnt_q;
	logic [TIME_W-1:0] x_q;
	logic [127:0]      acc_q;
	logic [31:0]       op_a;
	logic [31:0]       op_b;
	logic [63:0]       pp;
	logic [127:0]      pp_sh;

	// cnt bit 1 picks the dividend half, bit 0 the reciprocal half
	assign op_a = cnt_q[1] ? {1'b0, x_q[TIME_W-1:32]} : x_q[31:0];
	assign op_b = cnt_q[0] ? RECIP[63:32] : RECIP[31:0];
	assign pp = {32'b0, op_a} * {32'b0, op_b};

	always_comb begin
		case (cnt_q)
			2'd0: pp_sh = {64'b0, pp};
			2'd3: pp_sh = {pp, 64'b0};
			default: pp_sh = {32'b0, pp, 32'b0};
		endcase
	end

	assign busy = run_q | done_q;
	assign push = done_q & ~q_stat.full;
	assign push_data = TIME_W'(acc_q >> SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start && !busy) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 2'd3) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (push) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			x_q <= unix_time;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end
endmodule

/* design/totp_fifo.sv */
// Short queue of time-step counters between front and back.
// Depends on totp_pkg.
module totp_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [totp_pkg::TIME_W-1:0]   push_data,
	input  logic                          pop,
	output logic [totp_pkg::TIME_W-1:0]   pop_data,
	output totp_pkg::q_stat_t             q_stat
);
	import totp_pkg::*;

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);
	localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

	logic [TIME_W-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [NW-1:0]     count_q;

	assign q_stat.full = count_q == NW'(QUEUE_DEPTH);
	assign q_stat.empty = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

/* design/totp_back.sv */
// Back end: HMAC-SHA1 over one counter (four compressions, one round a cycle),
// dynamic truncation, decimal conversion and digit output. Depends on totp_pkg.
module totp_back #(
	parameter int unsigned KEY_BYTES = totp_pkg::KEY_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  totp_pkg::q_stat_t             q_stat,
	output logic                          pop,
	input  logic [totp_pkg::TIME_W-1:0]   pop_data,
	input  totp_pkg::key_t                key,
	input  logic [3:0]                    otp_len,
	output logic                          digit_valid,
	output logic [3:0]                    digit,
	output logic                          last_digit
);
	import totp_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_ROUND = 3'd2;
	localparam logic [2:0] S_FIN   = 3'd3;
	localparam logic [2:0] S_TRUNC = 3'd4;
	localparam logic [2:0] S_CONV  = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	localparam logic [1:0] BLK_KEY_IN  = 2'd0;
	localparam logic [1:0] BLK_CTR     = 2'd1;
	localparam logic [1:0] BLK_KEY_OUT = 2'd2;
	localparam logic [1:0] BLK_INNER   = 2'd3;

	logic [2:0]   state_q;
	logic [1:0]   blk_q;
	logic [6:0]   rnd_q;
	logic [63:0]  ctr_q;
	logic [31:0]  win_q [16];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [31:0]  h_q [5];
	logic [31:0]  inner_q [5];
	logic [30:0]  x_q;
	logic [3:0]   digs_q [8];
	logic [2:0]   idx_q;
	logic [2:0]   nm1_q;
	logic         digit_valid_q;
	logic [3:0]   digit_q;
	logic         last_q;

	logic [511:0] key_blk;
	logic [31:0]  msg [16];
	logic [31:0]  f, k, t;
	logic [31:0]  hn [5];
	logic [159:0] digest_sh;
	logic [3:0]   off;
	logic [62:0]  prod;
	logic [27:0]  quo;
	logic [3:0]   quo10_lo;
	logic [3:0]   rem_dig;
	logic [2:0]   nm1;

	// key padded to the HMAC block; bytes past KEY_BYTES are zero
	for (genvar i = 0; i < 64; i++) begin : g_key
		if (i < KEY_BYTES && i < NUM_KEY_WORDS * 8) begin : g_used
			assign key_blk[511-8*i -: 8] = key[i/8][63-8*(i%8) -: 8];
		end else begin : g_zero
			assign key_blk[511-8*i -: 8] = 8'h00;
		end
	end

	always_comb begin
		for (int j = 0; j < 16; j++) begin
			msg[j] = '0;
		end
		case (blk_q)
			BLK_KEY_IN: begin
				for (int j = 0; j < 16; j++) begin
					msg[j] = key_blk[511-32*j -: 32] ^ IPAD_WORD;
				end
			end
			BLK_CTR: begin
				msg[0] = ctr_q[63:32];
				msg[1] = ctr_q[31:0];
				msg[2] = PAD_WORD;
				msg[15] = INNER_LEN_BITS;
			end
			BLK_KEY_OUT: begin
				for (int j = 0; j < 16; j++) begin
					msg[j] = key_blk[511-32*j -: 32] ^ OPAD_WORD;
				end
			end
			default: begin
				for (int j = 0; j < 5; j++) begin
					msg[j] = inner_q[j];
				end
				msg[5] = PAD_WORD;
				msg[15] = OUTER_LEN_BITS;
			end
		endcase
	end

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + win_q[0];
	end

	assign hn[0] = h_q[0] + a_q;
	assign hn[1] = h_q[1] + b_q;
	assign hn[2] = h_q[2] + c_q;
	assign hn[3] = h_q[3] + d_q;
	assign hn[4] = h_q[4] + e_q;

	assign off = h_q[4][3:0];
	assign digest_sh = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]} << {off, 3'b000};

	// x / 10 by reciprocal; the remainder needs only the low four bits
	assign prod = 63'(x_q) * 63'(RECIP10);
	assign quo = prod[62:35];
	assign quo10_lo = {quo[0], 3'b000} + {quo[2:0], 1'b0};
	assign rem_dig = x_q[3:0] - quo10_lo;

	assign nm1 = (otp_len == 4'd0) ? 3'd0 :
		(otp_len > 4'd8) ? 3'd7 : 3'(otp_len - 4'd1);

	assign pop = (state_q == S_IDLE) && !q_stat.empty;

	assign digit_valid = digit_valid_q;
	assign digit = digit_q;
	assign last_digit = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			blk_q <= BLK_KEY_IN;
			rnd_q <= '0;
			idx_q <= '0;
			digit_valid_q <= 1'b0;
		end else begin
			digit_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						blk_q <= BLK_KEY_IN;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					rnd_q <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 7'd79) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (blk_q == BLK_INNER) begin
						state_q <= S_TRUNC;
					end else begin
						blk_q <= blk_q + 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_TRUNC: begin
					idx_q <= '0;
					state_q <= S_CONV;
				end
				S_CONV: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == nm1_q) begin
						idx_q <= nm1_q;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					digit_valid_q <= 1'b1;
					idx_q <= idx_q - 1'b1;
					if (idx_q == 3'd0) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ctr_q <= {1'b0, pop_data};
			end
			S_LOAD: begin
				for (int j = 0; j < 16; j++) begin
					win_q[j] <= msg[j];
				end
				if (blk_q == BLK_KEY_IN || blk_q == BLK_KEY_OUT) begin
					h_q[0] <= IV0; h_q[1] <= IV1; h_q[2] <= IV2; h_q[3] <= IV3; h_q[4] <= IV4;
					a_q <= IV0; b_q <= IV1; c_q <= IV2; d_q <= IV3; e_q <= IV4;
				end else begin
					a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
				end
			end
			S_ROUND: begin
				a_q <= t;
				b_q <= a_q;
				c_q <= {b_q[1:0], b_q[31:2]};
				d_q <= c_q;
				e_q <= d_q;
				for (int j = 0; j < 15; j++) begin
					win_q[j] <= win_q[j+1];
				end
				win_q[15] <= {win_q[13][30:0] ^ win_q[8][30:0] ^ win_q[2][30:0] ^ win_q[0][30:0],
					win_q[13][31] ^ win_q[8][31] ^ win_q[2][31] ^ win_q[0][31]};
			end
			S_FIN: begin
				for (int j = 0; j < 5; j++) begin
					h_q[j] <= hn[j];
				end
				if (blk_q == BLK_CTR) begin
					for (int j = 0; j < 5; j++) begin
						inner_q[j] <= hn[j];
					end
				end
			end
			S_TRUNC: begin
				x_q <= digest_sh[158:128];
				nm1_q <= nm1;
			end
			S_CONV: begin
				digs_q[idx_q] <= rem_dig;
				x_q <= {3'b000, quo};
			end
			S_EMIT: begin
				digit_q <= digs_q[idx_q];
				last_q <= idx_q == 3'd0;
			end
			default: begin
			end
		endcase
	end
endmodule

/* bench/testbench.sv */
// Self-checking bench for the TOTP generator: reset defaults, RFC 6238 vectors, digit counts, random keys/times.
// Depends on totp_pkg and totp_hmac_sha1_generator_unit; predicts every digit with its own HMAC-SHA1.
module testbench;
	import totp_pkg::*;

	localparam int WATCHDOG_LIMIT = 6000;

	typedef struct {
		logic [3:0] digit;
		logic       last;
	} otp_digit_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [TIME_W-1:0]    unix_time = '0;
	logic                 digit_valid;
	logic [3:0]           digit;
	logic                 last_digit;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [63:0]          wr_data = '0;

	key_t       key_shadow;
	logic [3:0] digits_shadow;
	otp_digit_t pending_digits[$];
	int         mismatches = 0;
	int         digits_checked = 0;
	int         requests_sent = 0;
	int         idle_cycles = 0;

	totp_hmac_sha1_generator_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .unix_time(unix_time),
		.digit_valid(digit_valid), .digit(digit), .last_digit(last_digit),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #6 clk = ~clk;

	function automatic logic [31:0] rotl(logic [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [159:0] sha1_compress(logic [159:0] h, logic [511:0] blk);
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++) w[i] = blk[511-32*i -: 32];
		for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		{a, b, c, d, e} = h;
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = K0;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = K1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = K2;
			end else begin
				f = b ^ c ^ d; k = K3;
			end
			t = rotl(a, 5) + f + e + k + w[i];
			e = d; d = c; c = rotl(b, 30); b = a; a = t;
		end
		return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
	endfunction

	// HMAC-SHA1 of the 8-byte counter, dynamic truncation, then split into digits
	task automatic predict_otp(logic [TIME_W-1:0] secs);
		logic [511:0] key_block;
		logic [159:0] iv, inner, mac;
		logic [63:0]  counter;
		logic [31:0]  bin, otp, scale;
		int           n, off;
		otp_digit_t   d;
		iv = {IV0, IV1, IV2, IV3, IV4};
		key_block = {key_shadow[0], key_shadow[1], key_shadow[2], key_shadow[3],
			key_shadow[4], key_shadow[5], key_shadow[6], 64'h0};
		counter = {1'b0, secs} / 64'd30;
		inner = sha1_compress(iv, key_block ^ {16{IPAD_WORD}});
		inner = sha1_compress(inner, {counter, PAD_WORD, 384'h0, INNER_LEN_BITS});
		mac = sha1_compress(iv, key_block ^ {16{OPAD_WORD}});
		mac = sha1_compress(mac, {inner, PAD_WORD, 288'h0, OUTER_LEN_BITS});
		off = int'(mac[3:0]);
		bin = mac[159-8*off -: 32] & 32'h7fff_ffff;
		n = int'(digits_shadow);
		if (n < 1) n = 1;
		if (n > 8) n = 8;
		scale = 1;
		for (int i = 0; i < n; i++) scale = scale * 10;
		otp = bin % scale;
		for (int i = 0; i < n; i++) begin
			scale = scale / 10;
			d.digit = 4'((otp / scale) % 10);
			d.last = (i == n - 1);
			pending_digits.push_back(d);
		end
	endtask

	task automatic report_mismatch(string what);
		$display("ERROR @%0t: %s", $realtime, what);
		mismatches++;
	endtask

	always @(posedge clk) begin
		otp_digit_t want;
		if (digit_valid) begin
			if (pending_digits.size() == 0) begin
				report_mismatch($sformatf("unexpected digit %0d", digit));
			end else begin
				want = pending_digits.pop_front();
				digits_checked++;
				if (digit !== want.digit)
					report_mismatch($sformatf("digit %0d, want %0d", digit, want.digit));
				if (last_digit !== want.last)
					report_mismatch($sformatf("last_digit %0b, want %0b", last_digit, want.last));
			end
		end
	end

	always @(posedge clk) begin
		if (digit_valid || (start && !busy) || wr_en) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d digits outstanding", pending_digits.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one request transfer; start stays high afterwards so back-to-back requests need no toggle
	task automatic send_time(logic [TIME_W-1:0] secs);
		int gap;
		gap = $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		unix_time <= secs;
		do @(posedge clk); while (busy);
		predict_otp(secs);
		requests_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_digits.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// write all registers; only called while idle
	task automatic load_config(key_t key, logic [63:0] count_word);
		for (int i = 0; i <= NUM_KEY_WORDS; i++) begin
			wr_en <= 1'b1;
			wr_index <= CFG_IDX_W'(i);
			wr_data <= (i == DIGIT_COUNT_IDX) ? count_word : key[i];
			@(posedge clk);
		end
		wr_en <= 1'b0;
		key_shadow = key;
		digits_shadow = count_word[3:0];
	endtask

	function automatic logic [TIME_W-1:0] random_time();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return r[TIME_W-1:0];
			1: return TIME_W'(r[30:0]);
			2: return TIME_W'((r[31:0] / 30) * 30 + $urandom_range(28, 31));
			default: return r[TIME_W-1:0] >> $urandom_range(0, 62);
		endcase
	endfunction

	function automatic key_t random_key();
		key_t k;
		int   len;
		len = $urandom_range(0, 3) == 0 ? 56 : $urandom_range(1, 56);
		for (int i = 0; i < NUM_KEY_WORDS; i++) k[i] = {$urandom, $urandom};
		for (int b = len; b < 56; b++) k[b/8][63-8*(b%8) -: 8] = 8'h00;
		return k;
	endfunction

	task automatic test_reset_defaults();
		key_shadow = '0;
		digits_shadow = 4'd6;
		send_time('0);
		send_time({TIME_W{1'b1}});
		send_time(63'd59);
		drain();
	endtask

	task automatic test_rfc_vectors();
		key_t k;
		k = '0;
		k[0] = 64'h3132_3334_3536_3738;
		k[1] = 64'h3930_3132_3334_3536;
		k[2] = 64'h3738_3930_0000_0000;
		load_config(k, 64'd8);
		send_time(63'd59);
		send_time(63'd1111111109);
		send_time(63'd1111111111);
		send_time(63'd1234567890);
		send_time(63'd2000000000);
		send_time(63'd20000000000);
		drain();
	endtask

	task automatic test_digit_counts();
		key_t        k;
		logic [3:0]  counts[6] = '{4'd0, 4'd1, 4'd8, 4'd9, 4'd15, 4'd7};
		k = '1;
		foreach (counts[i]) begin
			load_config(k, {$urandom, $urandom} & ~64'hf | counts[i]);
			send_time(random_time());
			send_time({TIME_W{1'b1}});
			drain();
			k = ~k;
		end
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 6; phase++) begin
			load_config(random_key(),
				64'($urandom_range(0, 5) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 8)));
			for (int i = 0; i < 50; i++) begin
				send_time(random_time());
				// let the pipeline run dry once in a while
				if ($urandom_range(0, 24) == 0) drain();
			end
			drain();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_rfc_vectors();
		test_digit_counts();
		test_random();
		repeat (50) @(posedge clk);
		$display("covered %0d requests, %0d digits checked, %0d mismatches",
			requests_sent, digits_checked, mismatches);
		if (mismatches == 0 && pending_digits.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

/* sim.f */
+incdir+design
design/totp_pkg.sv
design/totp_front.sv
design/totp_fifo.sv
design/totp_back.sv
design/totp_hmac_sha1_generator_unit.sv
bench/testbench.sv
